// ===== rtl/sorted_line_table_defines.svh =====
// Assertion macros shared by the sorted line table checker.
`ifndef SORTED_LINE_TABLE_DEFINES_SVH
`define SORTED_LINE_TABLE_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define SLT_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SLT_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (cons)) else $error(msg);

`endif

// ===== rtl/slt_pkg.sv =====
// Package for the sorted line table: sizes, codes and shared types.
package slt_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);

    // Request codes
    localparam logic [2:0] REQ_ADD     = 3'd0;
    localparam logic [2:0] REQ_REMOVE  = 3'd1;
    localparam logic [2:0] REQ_RD_TEXT = 3'd2;
    localparam logic [2:0] REQ_SET_ST  = 3'd3;
    localparam logic [2:0] REQ_RD_ST   = 3'd4;
    localparam logic [2:0] REQ_FIRST   = 3'd5;
    localparam logic [2:0] REQ_NEXT    = 3'd6;
    localparam logic [2:0] REQ_CLEAR   = 3'd7;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [15:0] key;
        logic [31:0] text;
        logic [31:0] stmt;
    } t_entry;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] line_number;
        logic [31:0] text_handle;
        logic [31:0] statement_handle;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] line_number;
        logic [31:0] text_handle;
        logic [31:0] statement_handle;
    } t_rsp;

endpackage

// ===== rtl/slt_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module slt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/slt_seq.sv =====
// Sequencer that walks the entry RAM to search, insert, remove, update and read.
module slt_seq
    import slt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    input  logic i_take,
    output logic o_busy,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHUP   = 3'd3;
    localparam logic [2:0] S_INS    = 3'd4;
    localparam logic [2:0] S_SHDN   = 3'd5;
    localparam logic [2:0] S_RDKEY  = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_req              r_req, n_req;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_found, n_found;
    logic [ADDR_W-1:0] r_sh, n_sh;
    t_entry            r_ent, n_ent;
    t_rsp              r_rsp, n_rsp;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    t_entry            ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    t_entry            ram_rdata;

    logic [CNT_W-1:0]  idx_ext;
    logic [CNT_W-1:0]  idx_p1;
    logic [CNT_W-1:0]  sh_p2;

    assign idx_ext = CNT_W'(r_idx);
    assign idx_p1  = CNT_W'(r_idx) + CNT_W'(1);
    assign sh_p2   = CNT_W'(r_sh) + CNT_W'(2);

    slt_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Step the sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_req     = r_req;
        n_idx     = r_idx;
        n_found   = r_found;
        n_sh      = r_sh;
        n_ent     = r_ent;
        n_rsp     = r_rsp;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = {r_req.line_number, r_req.text_handle, 32'd0};
        ram_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    n_rsp = '0;
                    n_idx = '0;
                    case (i_req.req_type)
                        REQ_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_DONE;
                        end
                        REQ_FIRST: begin
                            if (r_cnt == '0) begin
                                n_rsp.status = ST_NOT_FOUND;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_RDKEY;
                            end
                        end
                        default: begin
                            if (r_cnt == '0) begin
                                n_found = 1'b0;
                                n_state = S_DECIDE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                    endcase
                end
            end

            // Compare one entry per cycle against the key
            S_SCAN: begin
                if (ram_rdata.key >= r_req.line_number) begin
                    n_found = (ram_rdata.key == r_req.line_number);
                    n_ent   = ram_rdata;
                    n_state = S_DECIDE;
                end else if (idx_p1 == r_cnt) begin
                    n_found = 1'b0;
                    n_idx   = ADDR_W'(r_cnt);
                    n_state = S_DECIDE;
                end else begin
                    ram_raddr = r_idx + ADDR_W'(1);
                    n_idx     = r_idx + ADDR_W'(1);
                end
            end

            // Act on the search result
            S_DECIDE: begin
                n_state = S_DONE;
                case (r_req.req_type)
                    REQ_ADD: begin
                        if (r_found) begin
                            ram_we = 1'b1;
                        end else if (r_cnt == CNT_CAP) begin
                            n_rsp.status = ST_FULL;
                        end else if (idx_ext == r_cnt) begin
                            ram_we = 1'b1;
                            n_cnt  = r_cnt + CNT_W'(1);
                        end else begin
                            ram_raddr = ADDR_W'(r_cnt - CNT_W'(1));
                            n_sh      = ADDR_W'(r_cnt);
                            n_state   = S_SHUP;
                        end
                    end
                    REQ_REMOVE: begin
                        if (!r_found) begin
                            n_rsp.status = ST_NOT_FOUND;
                        end else if (idx_p1 == r_cnt) begin
                            n_cnt = r_cnt - CNT_W'(1);
                        end else begin
                            ram_raddr = r_idx + ADDR_W'(1);
                            n_sh      = r_idx;
                            n_state   = S_SHDN;
                        end
                    end
                    REQ_RD_TEXT: begin
                        if (r_found) begin
                            n_rsp.text_handle = r_ent.text;
                        end else begin
                            n_rsp.status = ST_NOT_FOUND;
                        end
                    end
                    REQ_SET_ST: begin
                        if (r_found) begin
                            ram_we    = 1'b1;
                            ram_wdata = {r_ent.key, r_ent.text, r_req.statement_handle};
                        end else begin
                            n_rsp.status = ST_NOT_FOUND;
                        end
                    end
                    REQ_RD_ST: begin
                        if (r_found) begin
                            n_rsp.statement_handle = r_ent.stmt;
                        end else begin
                            n_rsp.status = ST_NOT_FOUND;
                        end
                    end
                    REQ_NEXT: begin
                        if (r_found && (idx_p1 < r_cnt)) begin
                            ram_raddr = r_idx + ADDR_W'(1);
                            n_state   = S_RDKEY;
                        end else begin
                            n_rsp.status = ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        n_rsp.status = ST_OK;
                    end
                endcase
            end

            // Move entries up one slot, top first
            S_SHUP: begin
                ram_we    = 1'b1;
                ram_waddr = r_sh;
                ram_wdata = ram_rdata;
                if ((r_sh - ADDR_W'(1)) == r_idx) begin
                    n_state = S_INS;
                end else begin
                    ram_raddr = r_sh - ADDR_W'(2);
                    n_sh      = r_sh - ADDR_W'(1);
                end
            end

            // Write the new entry into the opened slot
            S_INS: begin
                ram_we  = 1'b1;
                n_cnt   = r_cnt + CNT_W'(1);
                n_state = S_DONE;
            end

            // Move entries down one slot, bottom first
            S_SHDN: begin
                ram_we    = 1'b1;
                ram_waddr = r_sh;
                ram_wdata = ram_rdata;
                if (sh_p2 == r_cnt) begin
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = S_DONE;
                end else begin
                    ram_raddr = r_sh + ADDR_W'(2);
                    n_sh      = r_sh + ADDR_W'(1);
                end
            end

            S_RDKEY: begin
                n_rsp.line_number = ram_rdata.key;
                n_state           = S_DONE;
            end

            // Hold the result until the output register takes it
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_req   <= n_req;
        r_idx   <= n_idx;
        r_found <= n_found;
        r_sh    <= n_sh;
        r_ent   <= n_ent;
        r_rsp   <= n_rsp;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_rsp  = r_rsp;

endmodule

// ===== rtl/sorted_line_table.sv =====
// Top level of the sorted line table: handshakes and output register.
//
// A table of up to CAPACITY entries kept in ascending line-number order,
// each holding a text handle and a statement handle, stored in one RAM.
// Input channel: i_in_valid / o_in_stall carry one request item (type,
// line number, text handle, statement handle). Output channel:
// o_out_valid / i_out_stall carry exactly one result item per request.
// One request is in work at a time; o_in_stall is high while it runs.
// Clear and first need no search; searched requests walk the entry RAM
// one word per cycle up to the named line. An insert then moves the
// entries from that position up one slot and writes the new one, and a
// remove moves the entries above that position down one slot.
// Reset empties the table (count to zero); RAM contents are not cleared.
// A stalled result holds in the output register; the sequencer finishes
// the next request only once that register frees up, and new requests
// are taken as soon as a result has moved into it.
module sorted_line_table
    import slt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_line_number,
    input  logic [31:0] i_text_handle,
    input  logic [31:0] i_statement_handle,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_line_number_out,
    output logic [31:0] o_text_handle_out,
    output logic [31:0] o_statement_handle_out
);

    logic r_out_valid;
    t_rsp r_out;
    t_req req;
    t_rsp rsp;
    logic busy;
    logic done;
    logic take;
    logic start;

    assign req   = {i_req_type, i_line_number, i_text_handle, i_statement_handle};
    assign start = i_in_valid && !busy;
    assign take  = !r_out_valid || !i_out_stall;

    slt_seq u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_req  (req),
        .i_take (take),
        .o_busy (busy),
        .o_done (done),
        .o_rsp  (rsp)
    );

    // Load the output register when it frees up, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= done;
        end
        if (take && done) begin
            r_out <= rsp;
        end
    end

    assign o_in_stall             = busy;
    assign o_out_valid            = r_out_valid;
    assign o_status               = r_out.status;
    assign o_line_number_out      = r_out.line_number;
    assign o_text_handle_out      = r_out.text_handle;
    assign o_statement_handle_out = r_out.statement_handle;

endmodule

// ===== rtl/slt_checker.sv =====
// Port-level checker for the sorted line table, bound to the top level.
`include "sorted_line_table_defines.svh"

module slt_checker
    import slt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [15:0] o_line_number_out,
    input logic [31:0] o_text_handle_out,
    input logic [31:0] o_statement_handle_out
);

    // An accepted item keeps the block busy in the next cycle
    `SLT_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "not busy after accept")

    // A stalled result holds
    `SLT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_line_number_out) && $stable(o_text_handle_out) && $stable(o_statement_handle_out), "stalled result changed")

    // Status is one of the defined codes
    `SLT_ASSERT_NOW(a_status_code, o_out_valid, o_status == ST_OK || o_status == ST_NOT_FOUND || o_status == ST_FULL, "bad status code")

    // A failed request returns zero data
    `SLT_ASSERT_NOW(a_fail_zero, o_out_valid && o_status != ST_OK, o_line_number_out == 16'd0 && o_text_handle_out == 32'd0 && o_statement_handle_out == 32'd0, "data on failed request")

endmodule

bind sorted_line_table slt_checker u_slt_checker (.*);
